FILE: sv/spq_pkg.sv
package spq_pkg;

    // Store size and field widths.
    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int PAYLOAD_BITS  = 16;
    localparam int CNT_BITS      = $clog2(CAPACITY + 1);

    // Fixed widths of the result fields.
    localparam int STATUS_BITS   = 2;
    localparam int OCC_BITS      = 5;

    // Operation codes.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One stored entry.
    typedef struct packed {
        logic [PAYLOAD_BITS-1:0]  payload;
        logic [PRIORITY_BITS-1:0] prio;
    } t_entry;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

FILE: sv/spq_cell.sv
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  logic               i_prev_ge,
    input  spq_pkg::t_entry    i_prev_entry,
    input  spq_pkg::t_entry    i_next_entry,
    output spq_pkg::t_entry    o_entry,
    output logic               o_ge
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // The entry stays ahead of a new one when its priority is equal or higher.
    assign o_ge    = i_occupied && (r_entry.prio >= i_ctl.new_entry.prio);
    assign o_entry = r_entry;

    // Insert shifts entries toward the tail; remove shifts toward the head.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (!i_prev_ge) begin
                n_entry = i_prev_entry;
            end else if (!o_ge) begin
                n_entry = i_ctl.new_entry;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: sv/stable_priority_queue_core.sv
// Channel   Ports                                        Direction  Handshake
// command   i_func, i_new_priority, i_new_payload        in         i_start high, o_busy low
// result    o_out_payload, o_out_priority, o_status,     out        o_strobe, one cycle
//           o_occupancy
//
// Each item's result appears on the cycle after it is accepted, so a new item may be
// started in every cycle and o_busy stays low.
// The rate is set by the row of cells, which all compare and shift in the same cycle.
// Reset is synchronous and clears only the entry count and the result strobe.
// The receiver cannot stall: each result is valid for exactly one cycle.
module stable_priority_queue_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_func,
    input  logic [spq_pkg::PRIORITY_BITS-1:0] i_new_priority,
    input  logic [spq_pkg::PAYLOAD_BITS-1:0]  i_new_payload,
    output logic                              o_strobe,
    output logic [spq_pkg::PAYLOAD_BITS-1:0]  o_out_payload,
    output logic [spq_pkg::PRIORITY_BITS-1:0] o_out_priority,
    output logic [spq_pkg::STATUS_BITS-1:0]   o_status,
    output logic [spq_pkg::OCC_BITS-1:0]      o_occupancy
);
    import spq_pkg::*;

    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    t_cell_ctl                w_ctl;
    t_entry                   w_entry [CAPACITY];
    logic                     w_ge    [CAPACITY];

    logic [CNT_BITS-1:0]      r_count;
    logic [CNT_BITS-1:0]      n_count;
    logic                     r_strobe;
    t_entry                   r_out;
    t_entry                   n_out;
    t_status                  r_status;
    t_status                  n_status;

    // The row never stalls, so no item is ever held off.
    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_full   = (r_count == CNT_BITS'(CAPACITY));
    assign w_empty  = (r_count == '0);

    // Broadcast control to the cells; dropped inserts and empty removes change nothing.
    assign w_ctl.ins               = w_accept && (i_func == FUNC_INSERT) && !w_full;
    assign w_ctl.rem               = w_accept && (i_func == FUNC_REMOVE) && !w_empty;
    assign w_ctl.new_entry.prio    = i_new_priority;
    assign w_ctl.new_entry.payload = i_new_payload;

    // Row of cells, slot 0 at the head.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic   w_prev_ge;
        t_entry w_prev_entry;
        t_entry w_next_entry;

        if (gi == 0) begin : g_head
            assign w_prev_ge    = 1'b1;
            assign w_prev_entry = w_ctl.new_entry;
        end else begin : g_body
            assign w_prev_ge    = w_ge[gi-1];
            assign w_prev_entry = w_entry[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign w_next_entry = w_entry[gi];
        end else begin : g_inner
            assign w_next_entry = w_entry[gi+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occupied   (CNT_BITS'(gi) < r_count),
            .i_prev_ge    (w_prev_ge),
            .i_prev_entry (w_prev_entry),
            .i_next_entry (w_next_entry),
            .o_entry      (w_entry[gi]),
            .o_ge         (w_ge[gi])
        );
    end

    // Next count and result contents.
    always_comb begin
        n_count  = r_count;
        n_out    = '0;
        n_status = ST_OK;
        if (i_func == FUNC_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_BITS'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count = r_count - CNT_BITS'(1);
                n_out   = w_entry[0];
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out    <= n_out;
            r_status <= n_status;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_out_payload  = r_out.payload;
    assign o_out_priority = r_out.prio;
    assign o_status       = r_status;
    assign o_occupancy    = OCC_BITS'(r_count);

    // A result appears only on the cycle after an accepted item.
    a_strobe_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(w_accept))
        else $error("result strobe without an accepted item");

    // The count never exceeds the store size.
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(CAPACITY))
        else $error("entry count beyond capacity");

    // An empty report leaves the queue empty, a full report leaves it full.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status == ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with stored entries");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_status == ST_FULL) |-> (r_count == CNT_BITS'(CAPACITY)))
        else $error("full status with free slots");

    // A remove that succeeds lowers the count by one.
    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.rem |=> (r_count == $past(r_count) - CNT_BITS'(1)))
        else $error("remove did not lower the count");

endmodule
